/* rtl/ohv_pkg.sv */
// Shared types, codes and character helpers for the onion host validator.
// No dependencies; used by the pack, store and top-level files and the testbench.
package ohv_pkg;

  localparam int NAME_LEN  = 62;
  localparam int BODY_LEN  = 56;
  localparam int WORDS     = 5;
  localparam int WORD_BITS = 56;
  localparam int NAME_BITS = WORDS * WORD_BITS;
  localparam int POS_W     = 7;
  localparam int CNT_W     = 7;
  localparam int TALLY_W   = 16;

  localparam logic [POS_W-1:0]   POS_MAX   = 7'd127;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;
  localparam logic [6:0]         CAP_RST   = 7'd64;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_DISC  = 2'd2;

  localparam logic [1:0] VERDICT_KEPT    = 2'd0;
  localparam logic [1:0] VERDICT_INVALID = 2'd1;
  localparam logic [1:0] VERDICT_DUP     = 2'd2;
  localparam logic [1:0] VERDICT_IGNORED = 2'd3;

  localparam logic [2:0] WORD_LAST = 3'd4;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [NAME_BITS-1:0] name_t;

  typedef struct packed {
    logic take;
    logic clear;
  } pack_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic first;
    logic last;
  } mem_ctl_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } scan_st_t;

  // {ok, base32 symbol}
  function automatic logic [5:0] classify(input logic [7:0] c);
    logic [7:0] d;
    begin
      if (c >= 8'h61 && c <= 8'h7A) begin
        d = c - 8'h61;
        classify = {1'b1, d[4:0]};
      end else if (c >= 8'h32 && c <= 8'h37) begin
        d = c - 8'h32 + 8'd26;
        classify = {1'b1, d[4:0]};
      end else begin
        classify = 6'd0;
      end
    end
  endfunction

  // ".onion"
  function automatic logic [7:0] suffix_char(input logic [2:0] idx);
    begin
      unique case (idx)
        3'd0:    suffix_char = 8'h2E;
        3'd1:    suffix_char = 8'h6F;
        3'd2:    suffix_char = 8'h6E;
        3'd3:    suffix_char = 8'h69;
        3'd4:    suffix_char = 8'h6F;
        3'd5:    suffix_char = 8'h6E;
        default: suffix_char = 8'h00;
      endcase
    end
  endfunction

  function automatic word_t name_word(input name_t n, input logic [2:0] w);
    begin
      unique case (w)
        3'd0:    name_word = n[0*WORD_BITS +: WORD_BITS];
        3'd1:    name_word = n[1*WORD_BITS +: WORD_BITS];
        3'd2:    name_word = n[2*WORD_BITS +: WORD_BITS];
        3'd3:    name_word = n[3*WORD_BITS +: WORD_BITS];
        3'd4:    name_word = n[4*WORD_BITS +: WORD_BITS];
        default: name_word = '0;
      endcase
    end
  endfunction

endpackage

/* rtl/ohv_if.sv */
// Valid/ready channel interfaces for hostname bytes and verdict words.
// Depends on nothing but the port widths of the block.
interface ohv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] host_char;
  logic       host_last;

  modport source(output valid, mode, host_char, host_last, input ready);
  modport sink(input valid, mode, host_char, host_last, output ready);
endinterface

interface ohv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [5:0]  slot_index;
  logic [6:0]  kept_total;
  logic [15:0] rejected_total;

  modport source(output valid, verdict, slot_index, kept_total, rejected_total, input ready);
  modport sink(input valid, verdict, slot_index, kept_total, rejected_total, output ready);
endinterface

/* rtl/ohv_pack.sv */
// Hostname assembler: byte position, running validity and base32 packing.
// Depends on ohv_pkg.
module ohv_pack (
  input  logic               clk,
  input  logic               rst_n,
  input  ohv_pkg::pack_ctl_t ctl,
  input  logic [7:0]         host_char,
  output logic [6:0]         pos,
  output logic               still_valid,
  output ohv_pkg::name_t     name
);

  logic [6:0]     pos_r, pos_nxt;
  logic           ok_r, ok_nxt;
  ohv_pkg::name_t name_r, name_nxt;
  logic [5:0]     cls;
  logic [6:0]     sfx_idx;

  assign cls     = ohv_pkg::classify(host_char);
  assign sfx_idx = pos_r - 7'(ohv_pkg::BODY_LEN);

  always_comb begin
    pos_nxt  = pos_r;
    ok_nxt   = ok_r;
    name_nxt = name_r;
    if (ctl.clear) begin
      pos_nxt = '0;
      ok_nxt  = 1'b1;
    end else if (ctl.take) begin
      if (pos_r < 7'(ohv_pkg::BODY_LEN)) begin
        name_nxt = {cls[4:0], name_r[ohv_pkg::NAME_BITS-1:5]};
        if (!cls[5]) ok_nxt = 1'b0;
      end else if (pos_r < 7'(ohv_pkg::NAME_LEN)) begin
        if (host_char != ohv_pkg::suffix_char(sfx_idx[2:0])) ok_nxt = 1'b0;
      end else begin
        ok_nxt = 1'b0;
      end
      if (pos_r != ohv_pkg::POS_MAX) pos_nxt = pos_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ok_r  <= 1'b1;
    end else begin
      pos_r <= pos_nxt;
      ok_r  <= ok_nxt;
    end
    name_r <= name_nxt;
  end

  assign pos         = pos_r;
  assign still_valid = ok_r;
  assign name        = name_r;

endmodule

/* rtl/ohv_store.sv */
// Hostname table memory with the shared word comparator for the duplicate scan.
// Depends on ohv_pkg.
module ohv_store #(
  parameter int MAX_PEERS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ohv_pkg::mem_ctl_t                 ctl,
  input  logic [$clog2(MAX_PEERS*5)-1:0]    addr,
  input  ohv_pkg::word_t                    word,
  output ohv_pkg::scan_st_t                 st
);

  localparam int DEPTH = MAX_PEERS * ohv_pkg::WORDS;

  ohv_pkg::word_t mem [DEPTH];
  ohv_pkg::word_t rdata_r;
  ohv_pkg::word_t cmp_r;
  logic           rd_valid_r;
  logic           first_r;
  logic           last_r;
  logic           acc_r;
  logic           cur_eq;
  logic           acc_eff;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[addr] <= word;
    if (ctl.rd_en) rdata_r <= mem[addr];
  end

  assign cur_eq  = (rdata_r == cmp_r);
  assign acc_eff = first_r ? cur_eq : (acc_r & cur_eq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= ctl.rd_en;
    end
    if (ctl.rd_en) begin
      cmp_r   <= word;
      first_r <= ctl.first;
      last_r  <= ctl.last;
    end
    if (rd_valid_r) acc_r <= acc_eff;
  end

  assign st.busy = rd_valid_r;
  assign st.hit  = rd_valid_r & last_r & acc_eff;

endmodule

/* rtl/onion_host_validate_dedup_merge_top.sv */
// Onion hostname validator, deduplicator and two-source merger. Hostname bytes
// and mode words are accepted while the block is idle. After the final byte of
// a new valid name in_ch.ready stays low through the scan and the write: one
// table word is read and compared per cycle over the single memory port, and a
// kept name is then written as five table words. A duplicate ends the scan at
// its matching entry, an invalid name or one offered beyond the room skips the
// scan and the write, and a verdict that finds the output register
// still full holds ready low until that register drains.
module onion_host_validate_dedup_merge_top #(
  parameter int MAX_PEERS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  ohv_in_if.sink      in_ch,
  ohv_out_if.source   out_ch
);

  localparam int AW = $clog2(MAX_PEERS * ohv_pkg::WORDS + 1);
  localparam int MW = $clog2(MAX_PEERS * ohv_pkg::WORDS);
  localparam int ROOM_RST = (64 > MAX_PEERS) ? MAX_PEERS : 64;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  cap_r;
  logic [6:0]  kept_r, kept_nxt;
  logic [15:0] tally_r, tally_nxt;
  logic [6:0]  offered_r, offered_nxt;
  logic [6:0]  room_r, room_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic [1:0]  res_verdict_r, res_verdict_nxt;
  logic [5:0]  res_slot_r, res_slot_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_verdict_r, out_verdict_nxt;
  logic [5:0]  out_slot_r, out_slot_nxt;
  logic [6:0]  out_kept_r, out_kept_nxt;
  logic [15:0] out_tally_r, out_tally_nxt;

  logic        in_acc;
  logic [6:0]  eff_cap;
  logic [AW-1:0] end_addr;
  logic        name_ok;

  ohv_pkg::pack_ctl_t pack_ctl;
  ohv_pkg::mem_ctl_t  mem_ctl;
  ohv_pkg::scan_st_t  scan_st;
  ohv_pkg::name_t     name;
  ohv_pkg::word_t     cur_word;
  logic [6:0]         pos;
  logic               still_valid;

  ohv_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (pack_ctl),
    .host_char   (in_ch.host_char),
    .pos         (pos),
    .still_valid (still_valid),
    .name        (name)
  );

  ohv_store #(
    .MAX_PEERS (MAX_PEERS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mem_ctl),
    .addr  (addr_r[MW-1:0]),
    .word  (cur_word),
    .st    (scan_st)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign eff_cap     = (32'(cap_r) > MAX_PEERS) ? 7'(MAX_PEERS) : cap_r;
  assign end_addr    = (AW'(kept_r) << 2) + AW'(kept_r);
  assign name_ok     = still_valid && (pos == 7'(ohv_pkg::NAME_LEN));
  assign cur_word    = ohv_pkg::name_word(name, wd_r);

  always_comb begin
    state_nxt       = state_r;
    kept_nxt        = kept_r;
    tally_nxt       = tally_r;
    offered_nxt     = offered_r;
    room_nxt        = room_r;
    addr_nxt        = addr_r;
    wd_nxt          = wd_r;
    res_verdict_nxt = res_verdict_r;
    res_slot_nxt    = res_slot_r;
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;
    out_slot_nxt    = out_slot_r;
    out_kept_nxt    = out_kept_r;
    out_tally_nxt   = out_tally_r;
    pack_ctl        = '0;
    mem_ctl         = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.mode)
            ohv_pkg::MODE_START: begin
              kept_nxt       = '0;
              tally_nxt      = '0;
              offered_nxt    = '0;
              room_nxt       = eff_cap;
              pack_ctl.clear = 1'b1;
            end
            ohv_pkg::MODE_DISC: begin
              offered_nxt    = '0;
              room_nxt       = (kept_r < eff_cap) ? (eff_cap - kept_r) : 7'd0;
              pack_ctl.clear = 1'b1;
            end
            ohv_pkg::MODE_BYTE: begin
              pack_ctl.take = 1'b1;
              if (in_ch.host_last) state_nxt = ST_EVAL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EVAL: begin
        res_slot_nxt = '0;
        if (offered_r >= room_r) begin
          res_verdict_nxt = ohv_pkg::VERDICT_IGNORED;
          state_nxt       = ST_DONE;
        end else begin
          offered_nxt = offered_r + 7'd1;
          if (!name_ok) begin
            res_verdict_nxt = ohv_pkg::VERDICT_INVALID;
            if (tally_r != ohv_pkg::TALLY_MAX) tally_nxt = tally_r + 16'd1;
            state_nxt = ST_DONE;
          end else begin
            addr_nxt  = '0;
            wd_nxt    = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_st.hit) begin
          res_verdict_nxt = ohv_pkg::VERDICT_DUP;
          state_nxt       = ST_DONE;
        end else if (addr_r != end_addr) begin
          mem_ctl.rd_en = 1'b1;
          mem_ctl.first = (wd_r == 3'd0);
          mem_ctl.last  = (wd_r == ohv_pkg::WORD_LAST);
          addr_nxt      = addr_r + AW'(1);
          wd_nxt        = (wd_r == ohv_pkg::WORD_LAST) ? 3'd0 : wd_r + 3'd1;
        end else if (!scan_st.busy) begin
          if (32'(kept_r) >= MAX_PEERS) begin
            res_verdict_nxt = ohv_pkg::VERDICT_IGNORED;
            state_nxt       = ST_DONE;
          end else begin
            wd_nxt    = '0;
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        mem_ctl.wr_en = 1'b1;
        addr_nxt      = addr_r + AW'(1);
        wd_nxt        = wd_r + 3'd1;
        if (wd_r == ohv_pkg::WORD_LAST) begin
          res_slot_nxt    = kept_r[5:0];
          kept_nxt        = kept_r + 7'd1;
          res_verdict_nxt = ohv_pkg::VERDICT_KEPT;
          state_nxt       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = res_verdict_r;
          out_slot_nxt    = res_slot_r;
          out_kept_nxt    = kept_r;
          out_tally_nxt   = tally_r;
          pack_ctl.clear  = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= ohv_pkg::CAP_RST;
      kept_r      <= '0;
      tally_r     <= '0;
      offered_r   <= '0;
      room_r      <= 7'(ROOM_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      kept_r      <= kept_nxt;
      tally_r     <= tally_nxt;
      offered_r   <= offered_nxt;
      room_r      <= room_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r        <= addr_nxt;
    wd_r          <= wd_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_slot_r    <= res_slot_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_slot_r    <= out_slot_nxt;
    out_kept_r    <= out_kept_nxt;
    out_tally_r   <= out_tally_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.verdict        = out_verdict_r;
  assign out_ch.slot_index     = out_slot_r;
  assign out_ch.kept_total     = out_kept_r;
  assign out_ch.rejected_total = out_tally_r;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for onion_host_validate_dedup_merge_top: sends hostname bytes and mode words,
// predicts every verdict word in-line and checks each one on the result channel.
// Depends on ohv_pkg, the ohv_in_if/ohv_out_if interfaces and the top-level block.
module tb;

  localparam int MAX_PEERS = 64;
  localparam int NAME_LEN = ohv_pkg::NAME_LEN;
  localparam int BODY_LEN = ohv_pkg::BODY_LEN;
  localparam int NAME_BITS = ohv_pkg::NAME_BITS;
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int SETTLE = 5 * MAX_PEERS + 16;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 700;
  localparam int ITEM_TARGET = 1550;
  localparam int POOL = 12;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_Z = 8'h7A;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_7 = 8'h37;
  localparam logic [47:0] ONION_SUFFIX = ".onion";
  localparam logic [47:0] OUTSIDE_BYTES = 48'h00_60_7B_31_38_FF;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [5:0]  slot;
    logic [6:0]  kept;
    logic [15:0] rejected;
  } verdict_word_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  ohv_in_if  in_if();
  ohv_out_if out_if();

  onion_host_validate_dedup_merge_top #(.MAX_PEERS(MAX_PEERS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // verdict predictor state
  logic [6:0]           capacity_q;
  logic [NAME_BITS-1:0] kept_names [MAX_PEERS];
  logic [NAME_BITS-1:0] packed_name;
  int                   kept_n;
  int                   invalid_n;
  int                   offered_n;
  int                   room_n;
  int                   pos_n;
  bit                   name_ok;
  verdict_word_t        verdicts_due [$];

  int  errors;
  int  words_sent;
  int  names_predicted;
  int  verdict_seen [4];
  int  quiet_cycles;
  int  hold_req;
  bit  gaps_on;
  bit  stalls_on;

  logic [7:0]            host_buf [256];
  int                    host_len;
  logic [8*BODY_LEN-1:0] body_pool [POOL];
  int                    pool_fill;

  function automatic int room_limit();
    return (capacity_q > MAX_PEERS) ? MAX_PEERS : int'(capacity_q);
  endfunction

  function automatic void clear_name();
    pos_n = 0;
    name_ok = 1'b1;
    packed_name = '0;
  endfunction

  function automatic void reset_model();
    capacity_q = 7'd64;
    kept_n = 0;
    invalid_n = 0;
    offered_n = 0;
    room_n = room_limit();
    clear_name();
  endfunction

  function automatic void predict_word(input logic [1:0] m, input logic [7:0] c,
                                       input logic l);
    verdict_word_t v;
    bit seen;
    if (m == ohv_pkg::MODE_START) begin
      kept_n = 0;
      invalid_n = 0;
      offered_n = 0;
      room_n = room_limit();
      clear_name();
    end else if (m == ohv_pkg::MODE_DISC) begin
      offered_n = 0;
      room_n = (kept_n < room_limit()) ? room_limit() - kept_n : 0;
      clear_name();
    end else if (m == ohv_pkg::MODE_BYTE) begin
      if (pos_n < BODY_LEN) begin
        if (c >= CH_A && c <= CH_Z) begin
          packed_name[pos_n*5 +: 5] = 5'(c - CH_A);
        end else if (c >= CH_2 && c <= CH_7) begin
          packed_name[pos_n*5 +: 5] = 5'(c - CH_2 + 8'd26);
        end else begin
          name_ok = 1'b0;
        end
      end else if (pos_n < NAME_LEN) begin
        if (c != ONION_SUFFIX[8*(NAME_LEN-1-pos_n) +: 8]) name_ok = 1'b0;
      end else begin
        name_ok = 1'b0;
      end
      if (pos_n < 127) pos_n++;
      if (l) begin
        v.slot = '0;
        if (offered_n >= room_n) begin
          v.verdict = ohv_pkg::VERDICT_IGNORED;
        end else begin
          offered_n++;
          seen = 1'b0;
          for (int i = 0; i < kept_n; i++) if (kept_names[i] == packed_name) seen = 1'b1;
          if (!name_ok || pos_n != NAME_LEN) begin
            v.verdict = ohv_pkg::VERDICT_INVALID;
            if (invalid_n < 65535) invalid_n++;
          end else if (seen) begin
            v.verdict = ohv_pkg::VERDICT_DUP;
          end else if (kept_n >= MAX_PEERS) begin
            v.verdict = ohv_pkg::VERDICT_IGNORED;
          end else begin
            v.verdict = ohv_pkg::VERDICT_KEPT;
            v.slot = 6'(kept_n);
            kept_names[kept_n] = packed_name;
            kept_n++;
          end
        end
        v.kept = 7'(kept_n);
        v.rejected = 16'(invalid_n);
        verdicts_due.push_back(v);
        names_predicted++;
        clear_name();
      end
    end
  endfunction

  function automatic logic [7:0] onion_char(input int sym);
    return (sym < 26) ? 8'(CH_A + sym) : 8'(CH_2 + sym - 26);
  endfunction

  function automatic bit in_alphabet(input logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || (c >= CH_2 && c <= CH_7);
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = OUTSIDE_BYTES[8*$urandom_range(0, 5) +: 8];
    end else begin
      do c = 8'($urandom); while (in_alphabet(c));
    end
    return c;
  endfunction

  function automatic logic [8*BODY_LEN-1:0] fresh_body();
    logic [8*BODY_LEN-1:0] b;
    for (int i = 0; i < BODY_LEN; i++) b[8*i +: 8] = onion_char($urandom_range(0, 31));
    return b;
  endfunction

  function automatic void build_name(input logic [8*BODY_LEN-1:0] body);
    for (int i = 0; i < BODY_LEN; i++) host_buf[i] = body[8*i +: 8];
    for (int k = 0; k < 6; k++) host_buf[BODY_LEN+k] = ONION_SUFFIX[8*(5-k) +: 8];
    host_len = NAME_LEN;
  endfunction

  function automatic void make_valid(input bit reuse);
    logic [8*BODY_LEN-1:0] body;
    if (reuse && pool_fill > 0) begin
      body = body_pool[$urandom_range(0, pool_fill - 1)];
    end else begin
      body = fresh_body();
      if (pool_fill < POOL) body_pool[pool_fill++] = body;
      else body_pool[$urandom_range(0, POOL - 1)] = body;
    end
    build_name(body);
  endfunction

  function automatic void make_invalid(input int kind);
    int idx;
    logic [7:0] c;
    build_name(fresh_body());
    case (kind)
      0: host_buf[$urandom_range(0, BODY_LEN - 1)] = bad_byte();
      1: begin
        idx = $urandom_range(BODY_LEN, NAME_LEN - 1);
        do c = 8'($urandom); while (c == host_buf[idx]);
        host_buf[idx] = c;
      end
      2: host_len = $urandom_range(1, NAME_LEN - 1);
      default: begin
        host_len = $urandom_range(NAME_LEN + 1, 200);
        for (int i = NAME_LEN; i < host_len; i++) host_buf[i] = 8'($urandom);
      end
    endcase
  endfunction

  task automatic send_word(input logic [1:0] m, input logic [7:0] c, input logic l);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.host_char <= c;
    in_if.host_last <= l;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    predict_word(m, c, l);
    if (m != MODE_NOP) words_sent++;
  endtask

  task automatic send_mode(input logic [1:0] m);
    send_word(m, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_host(input int nop_at);
    for (int i = 0; i < host_len; i++) begin
      if (i == nop_at) send_mode(MODE_NOP);
      send_word(ohv_pkg::MODE_BYTE, host_buf[i], i == host_len - 1);
    end
  endtask

  task automatic offer_fresh();
    make_valid(1'b0);
    send_host(-1);
  endtask

  // one-byte name: invalid while there is room, over room otherwise
  task automatic offer_stub();
    send_word(ohv_pkg::MODE_BYTE, 8'($urandom), 1'b1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_q = v;
  endtask

  task automatic test_validation();
    build_name({BODY_LEN{CH_A}});
    send_host(-1);
    build_name({(BODY_LEN/2){CH_Z, CH_2}});
    send_host(-1);
    send_host(-1);
    for (int k = 1; k < 5; k++) begin
      build_name(fresh_body());
      host_buf[$urandom_range(0, BODY_LEN - 1)] = OUTSIDE_BYTES[8*k +: 8];
      send_host(-1);
    end
    make_invalid(1);
    send_host(-1);
    build_name(fresh_body());
    host_len = NAME_LEN - 1;
    send_host(-1);
    host_len = 1;
    send_host(-1);
    make_invalid(3);
    host_len = NAME_LEN + 1;
    send_host(-1);
    make_invalid(3);
    host_len = 130;
    for (int i = NAME_LEN; i < host_len; i++) host_buf[i] = onion_char($urandom_range(0, 31));
    send_host(-1);
  endtask

  task automatic test_room_limits();
    set_capacity(7'd1);
    send_mode(ohv_pkg::MODE_START);
    offer_fresh();
    offer_stub();
    send_mode(ohv_pkg::MODE_DISC);
    offer_stub();
    set_capacity(7'd0);
    send_mode(ohv_pkg::MODE_START);
    offer_stub();
    offer_stub();
    set_capacity(7'd127);
    send_mode(ohv_pkg::MODE_START);
    offer_fresh();
    offer_stub();
    set_capacity(7'd3);
    send_mode(ohv_pkg::MODE_START);
    offer_fresh();
    send_host(-1);
    offer_stub();
    offer_stub();
    send_mode(ohv_pkg::MODE_DISC);
    offer_fresh();
    offer_stub();
    offer_stub();
    send_mode(ohv_pkg::MODE_DISC);
    offer_stub();
    offer_stub();
  endtask

  task automatic test_partial_drop();
    set_capacity(7'd64);
    send_mode(ohv_pkg::MODE_START);
    make_valid(1'b0);
    for (int i = 0; i < 20; i++) send_word(ohv_pkg::MODE_BYTE, host_buf[i], 1'b0);
    send_mode(ohv_pkg::MODE_DISC);
    send_host(20);
    for (int i = 0; i < 20; i++) send_word(ohv_pkg::MODE_BYTE, host_buf[i], 1'b0);
    send_mode(ohv_pkg::MODE_START);
    send_host(-1);
  endtask

  task automatic test_output_hold();
    set_capacity(7'd64);
    send_mode(ohv_pkg::MODE_START);
    gaps_on = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (12) offer_stub();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int pick;
    int part;
    int n;
    while (words_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: set_capacity(7'd0);
        1: set_capacity(7'd1);
        2: set_capacity(7'd127);
        3: set_capacity(7'd64);
        4: set_capacity(7'($urandom_range(9, 63)));
        default: set_capacity(7'($urandom_range(2, 8)));
      endcase
      send_mode(ohv_pkg::MODE_START);
      n = $urandom_range(4, 14);
      for (int j = 0; j < n && words_sent < ITEM_TARGET; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          make_valid(pick < 18);
          send_host(-1);
        end else if (pick < 70) begin
          make_invalid($urandom_range(0, 3));
          send_host(-1);
        end else if (pick < 80) begin
          send_mode(ohv_pkg::MODE_DISC);
        end else if (pick < 84) begin
          send_mode(ohv_pkg::MODE_START);
        end else if (pick < 92) begin
          make_valid(1'b1);
          part = $urandom_range(1, NAME_LEN - 1);
          for (int i = 0; i < part; i++)
            send_word(ohv_pkg::MODE_BYTE, host_buf[i], 1'b0);
          send_mode(pick < 88 ? ohv_pkg::MODE_START : ohv_pkg::MODE_DISC);
        end else begin
          make_valid(pick < 96);
          send_host($urandom_range(0, NAME_LEN - 1));
        end
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  function automatic void compare_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    verdict_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: verdict word with nothing pending, actual verdict %0d", $time,
                 out_if.verdict);
      end else begin
        want = verdicts_due.pop_front();
        verdict_seen[want.verdict]++;
        compare_field("verdict", 16'(want.verdict), 16'(out_if.verdict));
        compare_field("slot_index", 16'(want.slot), 16'(out_if.slot_index));
        compare_field("kept_total", 16'(want.kept), 16'(out_if.kept_total));
        compare_field("rejected_total", want.rejected, out_if.rejected_total);
      end
    end
  end

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    do begin
      @(posedge clk);
    end while (!rst_n);
    forever begin
      if (hold_req > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      gap = stalls_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!(out_if.valid && out_if.ready) && hold_req == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.mode <= ohv_pkg::MODE_BYTE;
    in_if.host_char <= '0;
    in_if.host_last <= 1'b0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_validation();
    test_room_limits();
    test_partial_drop();
    test_output_hold();
    test_random();
    drain();
    $display("summary: %0d words sent, %0d verdicts (kept %0d, invalid %0d, dup %0d, %s %0d)",
             words_sent, names_predicted, verdict_seen[ohv_pkg::VERDICT_KEPT],
             verdict_seen[ohv_pkg::VERDICT_INVALID], verdict_seen[ohv_pkg::VERDICT_DUP],
             "over room", verdict_seen[ohv_pkg::VERDICT_IGNORED]);
    $display("summary: capacities 0, 1, 3, 64, 127 and random, source switches, %s",
             "dropped partial names, long output hold-off");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ohv_pkg.sv
rtl/ohv_if.sv
rtl/ohv_pack.sv
rtl/ohv_store.sv
rtl/onion_host_validate_dedup_merge_top.sv
verif/tb.sv
